// ===== src/qdpf_pkg.sv =====
package qdpf_pkg;

  // Field and register widths
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned PIN_W         = 2;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned PERIOD_W      = 32;
  localparam int unsigned MIN_IV_W      = 20;
  localparam int unsigned WEIGHT_W      = 9;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT = 2'd1;

  // Reset values and limits
  localparam logic [MIN_IV_W-1:0] MIN_IV_RST  = 20'd5000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST  = 9'd102;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

  typedef logic [PIN_W-1:0]           pins_t;
  typedef logic [STAMP_W-1:0]         stamp_t;
  typedef logic signed [COUNT_W-1:0]  count_t;
  typedef logic [PERIOD_W-1:0]        period_t;

  // One pin-change event handed to the state units when it leaves the input register
  typedef struct packed {
    logic   en;
    pins_t  pins;
    stamp_t stamp;
  } event_t;

  // Gray position of the pin pair: 00,01,11,10 -> 0,1,2,3
  function automatic logic [1:0] gray_pos(input pins_t p);
    logic [1:0] g;
    case (p)
      2'b00:   g = 2'd0;
      2'b01:   g = 2'd1;
      2'b11:   g = 2'd2;
      default: g = 2'd3;
    endcase
    return g;
  endfunction

  // Position change wrapped into -1..+2 (mod-4 difference, 3 means -1)
  function automatic count_t step_delta(input pins_t old_p, input pins_t new_p);
    logic [1:0] diff;
    count_t     d;
    diff = gray_pos(new_p) - gray_pos(old_p);
    case (diff)
      2'd0:    d = '0;
      2'd1:    d = count_t'(1);
      2'd2:    d = count_t'(2);
      default: d = '1;
    endcase
    return d;
  endfunction

endpackage

// ===== src/qdpf_if.sv =====
interface qdpf_in_if;
  logic                   valid;
  logic                   ready;
  qdpf_pkg::pins_t        pin_levels;
  qdpf_pkg::stamp_t       event_time_us;

  modport source(output valid, pin_levels, event_time_us, input ready);
  modport sink(input valid, pin_levels, event_time_us, output ready);
endinterface

interface qdpf_out_if;
  logic                   valid;
  logic                   ready;
  qdpf_pkg::count_t       step_count;
  qdpf_pkg::period_t      step_period_us;
  logic                   period_updated;

  modport source(output valid, step_count, step_period_us, period_updated, input ready);
  modport sink(input valid, step_count, step_period_us, period_updated, output ready);
endinterface

// ===== src/qdpf_count.sv =====
module qdpf_count (
  input  logic             clk,
  input  logic             rst_n,
  input  qdpf_pkg::event_t evt,
  output qdpf_pkg::count_t count_nxt
);
  import qdpf_pkg::*;

  count_t position_r;
  pins_t  prev_pins_r;

  // New step count for this event
  assign count_nxt = position_r + step_delta(prev_pins_r, evt.pins);

  // Pin state is stored on every event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      prev_pins_r <= '0;
    end else if (evt.en) begin
      position_r  <= count_nxt;
      prev_pins_r <= evt.pins;
    end
  end

endmodule

// ===== src/qdpf_period.sv =====
module qdpf_period #(
  parameter int unsigned TIME_BITS = qdpf_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qdpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qdpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  qdpf_pkg::event_t                    evt,
  output qdpf_pkg::period_t                   period_nxt,
  output logic                                pass
);
  import qdpf_pkg::*;

  logic [MIN_IV_W-1:0]      min_iv_r;
  logic [WEIGHT_W-1:0]      weight_r;
  logic [TIME_BITS-1:0]     last_r;
  period_t                  period_r;

  logic [TIME_BITS+31:0]    stamp_ext;
  logic [TIME_BITS-1:0]     now;
  logic [TIME_BITS-1:0]     elapsed;
  logic [TIME_BITS+31:0]    el_ext;
  period_t                  e_sat;
  logic [WEIGHT_W-1:0]      w_sat;
  logic signed [32:0]       diff;
  logic signed [9:0]        w_s;
  logic signed [42:0]       prod;
  logic [34:0]              blend;

  // Timestamp fitted to the time counter width
  assign stamp_ext = {{TIME_BITS{1'b0}}, evt.stamp};
  assign now       = stamp_ext[TIME_BITS-1:0];
  assign elapsed   = now - last_r;
  assign el_ext    = {32'b0, elapsed};
  assign e_sat     = (|el_ext[TIME_BITS+31:32]) ? '1 : el_ext[31:0];

  // Interval gate
  assign pass = el_ext >= {{(TIME_BITS+12){1'b0}}, min_iv_r};

  // Average as old + floor((e - old) * w / 256)
  assign w_sat = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
  assign diff  = $signed({1'b0, e_sat}) - $signed({1'b0, period_r});
  assign w_s   = $signed({1'b0, w_sat});
  assign prod  = diff * w_s;
  assign blend = {3'b0, period_r} + prod[42:8];

  always_comb begin
    if (!pass) begin
      period_nxt = period_r;
    end else if (period_r == '0) begin
      period_nxt = e_sat;
    end else begin
      period_nxt = blend[31:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_iv_r <= MIN_IV_RST;
      weight_r <= WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_INTERVAL:  min_iv_r <= cfg_wdata[MIN_IV_W-1:0];
        CFG_SMOOTH_WEIGHT: weight_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Period state, moves only on events that pass the gate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      period_r <= '0;
    end else if (evt.en && pass) begin
      last_r   <= now;
      period_r <= period_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_last_follows_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.en && pass) |=> last_r == $past(now))
    else $error("last accepted time not taken from gated event");
  a_period_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.en && pass) |=> $stable(period_r) && $stable(last_r))
    else $error("period state moved without an accepted event");
  a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.en && pass && period_r == '0) |=> period_r == $past(e_sat))
    else $error("zero period not loaded directly");
`endif

endmodule

// ===== src/quadrature_decoder_period_filter.sv =====
// Quadrature x4 decoder with smoothed step period.
//
// in_ch carries one pin-change event per transaction: pin_levels (bit0 A,
// bit1 B) and a free-running microsecond timestamp. out_ch returns one
// transaction per event: the wrapped signed step count, the smoothed period
// in microseconds and a flag that the event passed the interval gate.
// cfg_we/cfg_index/cfg_wdata write the minimum interval (index 0) and the
// Q8 smoothing weight (index 1); other indexes are ignored.
//
// Throughput is one event per cycle while out_ch does not stall. An event
// sits in the input register; as it leaves, the count and period update and
// the result register loads, and the result is then offered on out_ch. The
// state update (one 33x10 multiply and add) is combinational between the
// input and result registers.
//
// Synchronous reset clears the pipeline, the count, the stored pins, the
// last accepted time and the period, and loads the register defaults.
// When out_ch stalls, the result register holds, the input register fills,
// and in_ch.ready drops until the result is taken.
module quadrature_decoder_period_filter #(
  parameter int unsigned TIME_BITS = qdpf_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  qdpf_in_if.sink                          in_ch,
  qdpf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [qdpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qdpf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import qdpf_pkg::*;

  logic    s1_vld_r;
  pins_t   s1_pins_r;
  stamp_t  s1_stamp_r;
  logic    out_vld_r;
  count_t  out_count_r;
  period_t out_period_r;
  logic    out_upd_r;

  logic    out_adv;
  logic    s1_fire;
  logic    in_fire;
  event_t  evt;
  count_t  count_nxt;
  period_t period_nxt;
  logic    pass;

  // Handshake: the input register moves when the result register is free
  assign out_adv     = !out_vld_r || out_ch.ready;
  assign s1_fire     = s1_vld_r && out_adv;
  assign in_ch.ready = !s1_vld_r || out_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign evt = '{en: s1_fire, pins: s1_pins_r, stamp: s1_stamp_r};

  qdpf_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .count_nxt (count_nxt)
  );

  qdpf_period #(
    .TIME_BITS (TIME_BITS)
  ) u_period (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .evt        (evt),
    .period_nxt (period_nxt),
    .pass       (pass)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= in_fire || (s1_vld_r && !out_adv);
      out_vld_r <= s1_fire || (out_vld_r && !out_ch.ready);
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pins_r  <= in_ch.pin_levels;
      s1_stamp_r <= in_ch.event_time_us;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_count_r  <= count_nxt;
      out_period_r <= period_nxt;
      out_upd_r    <= pass;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.step_count     = out_count_r;
  assign out_ch.step_period_us = out_period_r;
  assign out_ch.period_updated = out_upd_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !s1_vld_r)
    else $error("pipeline not empty after reset");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both registers are full");
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_vld_r)
    else $error("event left input register without a result");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import qdpf_pkg::*;

  // Spare register indexes: writes there must leave both registers alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    count_t  step_count;
    period_t step_period_us;
    logic    period_updated;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  qdpf_in_if  in_ch();
  qdpf_out_if out_ch();

  quadrature_decoder_period_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state as the block should hold it
  logic [MIN_IV_W-1:0] gate_us;
  logic [WEIGHT_W-1:0] weight;
  count_t  track_pos;
  pins_t   prev_pins;
  stamp_t  last_accept;
  period_t avg_period;

  motion_result_t expected_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit burst = 1'b0;

  // Stimulus generator state
  stamp_t clock_us;
  int phase_idx = 0;
  int heading = 1;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Gray rank of the pin pair: 00,01,10,11 -> 0,1,3,2
  function automatic int gray_rank(input pins_t p);
    return p[1] ? (p[0] ? 2 : 3) : (p[0] ? 1 : 0);
  endfunction

  // Count update, interval gate and period average for one event
  function automatic motion_result_t decode_event(input pins_t p, input stamp_t t);
    int d;
    stamp_t elapsed;
    logic [WEIGHT_W-1:0] w;
    logic [63:0] acc;
    motion_result_t r;
    d = gray_rank(p) - gray_rank(prev_pins);
    if (d > 2) d -= 4;
    if (d <= -2) d += 4;
    track_pos = track_pos + count_t'(d);
    prev_pins = p;
    elapsed = t - last_accept;
    r.period_updated = 1'b0;
    if (elapsed >= stamp_t'(gate_us)) begin
      if (avg_period != '0) begin
        w = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
        acc = 64'(avg_period) * (64'd256 - 64'(w)) + 64'(elapsed) * 64'(w);
        avg_period = period_t'(acc >> 8);
      end else begin
        avg_period = elapsed;
      end
      last_accept = t;
      r.period_updated = 1'b1;
    end
    r.step_count = track_pos;
    r.step_period_us = avg_period;
    return r;
  endfunction

  // Encoder motion: mostly single Gray steps, some reversals, holds and jumps
  function automatic pins_t next_pins();
    int r;
    logic [1:0] ph;
    r = $urandom_range(0, 99);
    if (r < 5) heading = -heading;
    if (r < 85) phase_idx = (phase_idx + heading) & 3;
    else if (r >= 93) phase_idx = $urandom_range(0, 3);
    ph = phase_idx[1:0];
    return {ph[1], ph[1] ^ ph[0]};
  endfunction

  // Timestamps around the gate interval, some short, a few random jumps
  function automatic stamp_t next_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      clock_us += stamp_t'(gate_us) + stamp_t'($urandom_range(0, gate_us / 2 + 20));
    else if (r < 80)
      clock_us += stamp_t'($urandom_range(0, gate_us));
    else if (r < 95)
      clock_us += stamp_t'($urandom_range(0, 50));
    else
      clock_us = $urandom;
    return clock_us;
  endfunction

  // One event transaction, with a random lead-in gap
  task automatic send_event(input pins_t p, input stamp_t t);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pin_levels <= p;
    in_ch.event_time_us <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(decode_event(p, t));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_INTERVAL) gate_us = data[MIN_IV_W-1:0];
    else if (idx == CFG_SMOOTH_WEIGHT) weight = data[WEIGHT_W-1:0];
  endtask

  task automatic run_motion(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      send_event(next_pins(), next_stamp());
    end
    burst = 1'b0;
  endtask

  // Pin transitions of every step size at the default registers, gate on both sides
  task automatic test_pin_decoding();
    send_event(2'b01, 32'd0);
    send_event(2'b11, 32'd5000);
    send_event(2'b10, 32'd5100);
    send_event(2'b00, 32'd20000);
    send_event(2'b10, 32'd20001);
    send_event(2'b01, 32'd20002);
    send_event(2'b10, 32'd26000);
    send_event(2'b10, 32'd26001);
    send_event(2'b11, 32'd40000);
    send_event(2'b00, 32'd40001);
  endtask

  // Elapsed time across the timestamp wrap
  task automatic test_timestamp_wrap();
    send_event(2'b01, 32'hFFFF_FFF0);
    send_event(2'b11, 32'h0000_2000);
    send_event(2'b11, 32'hFFFF_FFFF);
  endtask

  // Register extremes, zero period reload and ignored indexes
  task automatic test_register_extremes();
    write_reg(CFG_MIN_INTERVAL, '0);
    write_reg(CFG_SMOOTH_WEIGHT, CFG_DATA_W'(WEIGHT_FULL));
    send_event(2'b00, 32'h100);
    send_event(2'b01, 32'h100);
    send_event(2'b11, 32'h300);
    write_reg(CFG_SMOOTH_WEIGHT, '0);
    send_event(2'b10, 32'h400);
    // weight field all ones saturates to a full weight
    write_reg(CFG_SMOOTH_WEIGHT, '1);
    send_event(2'b00, 32'h900);
    write_reg(CFG_MIN_INTERVAL, '1);
    send_event(2'b01, 32'h900 + 32'd1000);
    send_event(2'b11, 32'h900 + 32'hF_FFFF);
    write_reg(CFG_SPARE_2, '0);
    write_reg(CFG_SPARE_3, '0);
    send_event(2'b10, 32'h900 + 32'hF_FFFF + 32'd1);
    clock_us = 32'h900 + 32'hF_FFFF + 32'd1;
  endtask

  task automatic test_random_motion();
    write_reg(CFG_MIN_INTERVAL, 20'd5000);
    write_reg(CFG_SMOOTH_WEIGHT, 20'd102);
    run_motion(500);
    write_reg(CFG_MIN_INTERVAL, 20'd1000);
    write_reg(CFG_SMOOTH_WEIGHT, 20'd200);
    run_motion(300);
  endtask

  // Receiver holds off while events keep coming, then a full drain
  task automatic test_backpressure();
    wait_idle();
    hold_req = HOLD_CYCLES;
    burst = 1'b1;
    for (int i = 0; i < 40; i++) send_event(next_pins(), next_stamp());
    burst = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_config();
    logic [CFG_DATA_W-1:0] data;
    for (int k = 0; k < 6; k++) begin
      case (k % 4)
        0:       data = '0;
        1:       data = '1;
        2:       data = CFG_DATA_W'($urandom_range(1, 3000));
        default: data = CFG_DATA_W'($urandom);
      endcase
      write_reg(CFG_MIN_INTERVAL, data);
      data = CFG_DATA_W'($urandom);
      if (k == 2) data[WEIGHT_W-1:0] = WEIGHT_FULL;
      write_reg(CFG_SMOOTH_WEIGHT, data);
      run_motion(120);
    end
  endtask

  // Result checking and receiver stalls
  initial begin
    motion_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, step_count %0d", $time,
                   out_ch.step_count);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.step_count !== want.step_count) begin
            mismatches++;
            $display("%0t: step_count expected %0d actual %0d", $time,
                     want.step_count, out_ch.step_count);
          end
          if (out_ch.step_period_us !== want.step_period_us) begin
            mismatches++;
            $display("%0t: step_period_us expected %0d actual %0d", $time,
                     want.step_period_us, out_ch.step_period_us);
          end
          if (out_ch.period_updated !== want.period_updated) begin
            mismatches++;
            $display("%0t: period_updated expected %0b actual %0b", $time,
                     want.period_updated, out_ch.period_updated);
          end
        end
      end
      // next cycle's ready: long hold first, then random stalls
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = burst ? 0 : pick_gap();
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    gate_us = MIN_IV_RST;
    weight = WEIGHT_RST;
    track_pos = '0;
    prev_pins = '0;
    last_accept = '0;
    avg_period = '0;
    clock_us = '0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.pin_levels <= '0;
    in_ch.event_time_us <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pin_decoding();
    test_timestamp_wrap();
    test_register_extremes();
    test_random_motion();
    test_backpressure();
    test_random_config();

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
src/qdpf_pkg.sv
src/qdpf_if.sv
src/qdpf_count.sv
src/qdpf_period.sv
src/quadrature_decoder_period_filter.sv
bench/testbench.sv
